// ===== rtl/isort_pkg.sv =====
// ----------------------------------------------------------------------------
// isort_pkg
// Shared command and status types between the sort controller and datapath.
// ----------------------------------------------------------------------------
package isort_pkg;

	// field widths fixed by the channel payloads
	localparam int unsigned ValueBits = 32;

	// commands from controller to datapath
	typedef struct packed {
		logic take_in;   // accept an input item, latch it
		logic shift;     // move the entry at j-1 up to j
		logic put;       // write the new element at j, count it
		logic emit_ld;   // load the next sorted entry into the output register
	} isort_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;        // store holds DEPTH entries
		logic count_zero;  // store is empty
		logic item_last;   // last mark on the offered input item
		logic last;        // last mark of the item being inserted
		logic goes_after;  // stored entry must follow the new element
		logic j_one;       // insertion point has reached slot one
		logic emit_end;    // entry being emitted is the final one
		logic out_free;    // output register can take a new result
	} isort_sts_t;

endpackage

// ===== rtl/isort_in_if.sv =====
// ----------------------------------------------------------------------------
// isort_in_if
// Input element channel: one signed value and a last-of-set mark.
// ----------------------------------------------------------------------------
interface isort_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== rtl/isort_out_if.sv =====
// ----------------------------------------------------------------------------
// isort_out_if
// Result channel: sorted values with end-of-set and overflow marks.
// ----------------------------------------------------------------------------
interface isort_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sorted_value;
	logic               end_of_set;
	logic               overflow;

	modport source (output valid, output sorted_value, output end_of_set,
		output overflow, input ready);
	modport sink   (input valid, input sorted_value, input end_of_set,
		input overflow, output ready);
endinterface

// ===== rtl/isort_cfg_if.sv =====
// ----------------------------------------------------------------------------
// isort_cfg_if
// Configuration write channel for the sort order bit.
// ----------------------------------------------------------------------------
interface isort_cfg_if;
	logic valid;
	logic ready;
	logic descending;

	modport source (output valid, output descending, input ready);
	modport sink   (input valid, input descending, output ready);
endinterface

// ===== rtl/isort_dp.sv =====
// ----------------------------------------------------------------------------
// isort_dp
// Sort datapath: element store, insertion pointer, counters and output register.
// ----------------------------------------------------------------------------
module isort_dp import isort_pkg::*; #(
	parameter int unsigned DEPTH        = 32,
	parameter int unsigned ELEMENT_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic signed [ValueBits-1:0] item_value,
	input  logic                        item_last,
	input  logic                        cfg_we,
	input  logic                        cfg_descending,
	input  isort_cmd_t                  cmd,
	output isort_sts_t                  sts,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic signed [ValueBits-1:0] out_value,
	output logic                        out_end,
	output logic                        out_ovf
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [ELEMENT_BITS-1:0] mem_q [DEPTH];
	logic [ELEMENT_BITS-1:0] rd_data_q;
	logic [ELEMENT_BITS-1:0] elem_q;
	logic                    last_q;
	logic [AW-1:0]           j_q;
	logic [CW-1:0]           count_q;
	logic                    dropped_q;
	logic                    desc_q;
	logic [AW-1:0]           emit_idx_q;
	logic                    out_valid_q;
	logic [ValueBits-1:0]    out_value_q;
	logic                    out_end_q;
	logic                    out_ovf_q;

	logic signed [63:0]      val_ext;
	logic signed [63:0]      rd_ext;
	logic [ELEMENT_BITS-1:0] elem_in;
	logic [AW-1:0]           rd_addr;
	logic                    we;
	logic [ELEMENT_BITS-1:0] wdata;
	logic                    full;
	logic                    emit_end;
	logic                    out_free;
	logic                    goes_after;

	// cut the input to the element width, sign extended from 32 bits
	assign val_ext = 64'(item_value);
	assign elem_in = val_ext[ELEMENT_BITS-1:0];
	assign rd_ext  = 64'($signed(rd_data_q));

	assign full     = (count_q == CW'(DEPTH));
	assign emit_end = ((CW'(emit_idx_q) + CW'(1)) == count_q);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		if (desc_q) begin
			goes_after = ($signed(rd_data_q) < $signed(elem_q));
		end else begin
			goes_after = ($signed(rd_data_q) > $signed(elem_q));
		end
	end

	always_comb begin
		if (cmd.take_in) begin
			rd_addr = AW'(count_q - CW'(1));
		end else if (cmd.shift) begin
			rd_addr = j_q - AW'(2);
		end else begin
			rd_addr = emit_idx_q;
		end
	end

	assign we    = cmd.shift || cmd.put;
	assign wdata = cmd.shift ? rd_data_q : elem_q;

	// element store, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[j_q] <= wdata;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			elem_q <= elem_in;
			last_q <= item_last;
		end
		if (cmd.emit_ld) begin
			out_value_q <= rd_ext[ValueBits-1:0];
			out_end_q   <= emit_end;
			out_ovf_q   <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q         <= '0;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			desc_q      <= 1'b0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				desc_q <= cfg_descending;
			end
			if (cmd.take_in) begin
				j_q <= count_q[AW-1:0];
				if (full) begin
					dropped_q <= 1'b1;
				end
			end else if (cmd.shift) begin
				j_q <= j_q - AW'(1);
			end
			if (cmd.put) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.emit_ld) begin
				out_valid_q <= 1'b1;
				if (emit_end) begin
					count_q    <= '0;
					dropped_q  <= 1'b0;
					emit_idx_q <= '0;
				end else begin
					emit_idx_q <= emit_idx_q + AW'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts            = '0;
		sts.full       = full;
		sts.count_zero = (count_q == '0);
		sts.item_last  = item_last;
		sts.last       = last_q;
		sts.goes_after = goes_after;
		sts.j_one      = (j_q == AW'(1));
		sts.emit_end   = emit_end;
		sts.out_free   = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_end   = out_end_q;
	assign out_ovf   = out_ovf_q;

endmodule

// ===== rtl/isort_ctrl.sv =====
// ----------------------------------------------------------------------------
// isort_ctrl
// Sort controller: sequences insertion, shifting and emission of the set.
// ----------------------------------------------------------------------------
module isort_ctrl import isort_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	output isort_cmd_t cmd,
	input  isort_sts_t sts
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_CMP     = 3'd1;
	localparam logic [2:0] S_PUT     = 3'd2;
	localparam logic [2:0] S_EMIT_RD = 3'd3;
	localparam logic [2:0] S_EMIT_LD = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_next;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		item_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.take_in = 1'b1;
					if (sts.full) begin
						state_next = sts.item_last ? S_EMIT_RD : S_IDLE;
					end else if (sts.count_zero) begin
						state_next = S_PUT;
					end else begin
						state_next = S_CMP;
					end
				end
			end
			S_CMP: begin
				if (sts.goes_after) begin
					cmd.shift = 1'b1;
					if (sts.j_one) begin
						state_next = S_PUT;
					end
				end else begin
					cmd.put    = 1'b1;
					state_next = sts.last ? S_EMIT_RD : S_IDLE;
				end
			end
			S_PUT: begin
				cmd.put    = 1'b1;
				state_next = sts.last ? S_EMIT_RD : S_IDLE;
			end
			S_EMIT_RD: begin
				// store read of the next entry is in flight
				state_next = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				if (sts.out_free) begin
					cmd.emit_ld = 1'b1;
					state_next  = sts.emit_end ? S_IDLE : S_EMIT_RD;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ===== rtl/insertion_sort_engine.sv =====
// ----------------------------------------------------------------------------
// insertion_sort_engine
// Sorts a set of signed values by insertion and streams the sorted set out.
// ----------------------------------------------------------------------------
// Usage:
//   item: one signed value per transaction, last marks the end of the set.
//   result: the sorted set, one value per transaction, end_of_set on the
//     final one, overflow on every value of a set that lost elements.
//   cfg: writes the order bit (0 ascending, 1 descending); write it only
//     while no set is being inserted or emitted.
// Insertion: an item is dropped when the store is full; otherwise k stored
//   entries move up before it is written, with k = 0 when it goes at the top
//   and k at most DEPTH - 1. One store read port is shared by the
//   compare/shift loop, so one entry moves per cycle.
// Emission: after the last item is inserted, each result is read from the
//   store, then loaded into the output register once that register is free.
// Stall: a held result blocks the next store read; no input is taken until
//   the final result is in the output register, which then frees the input.
// Reset: empties the store, clears the dropped mark and selects ascending.
// ----------------------------------------------------------------------------
module insertion_sort_engine import isort_pkg::*; #(
	parameter int unsigned DEPTH        = 32,
	parameter int unsigned ELEMENT_BITS = 32
) (
	input logic         clk,
	input logic         arst_n,
	isort_in_if.sink    item,
	isort_out_if.source result,
	isort_cfg_if.sink   cfg
);

	isort_cmd_t cmd;
	isort_sts_t sts;

	assign cfg.ready = 1'b1;

	isort_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	isort_dp #(
		.DEPTH        (DEPTH),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_value     (item.value),
		.item_last      (item.last),
		.cfg_we         (cfg.valid),
		.cfg_descending (cfg.descending),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.out_value      (result.sorted_value),
		.out_end        (result.end_of_set),
		.out_ovf        (result.overflow)
	);

	// at most one datapath operation per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take_in, cmd.shift, cmd.put, cmd.emit_ld}))
		else $error("more than one datapath command at once");

	// a shift only happens when the stored entry must follow the new one
	a_shift_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> sts.goes_after)
		else $error("shift without a successful compare");

	// a result appears only after an output load
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.emit_ld))
		else $error("result valid without a load");

	// no input is taken while the set is being emitted
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_ld |-> !item.ready)
		else $error("input ready during emission");

endmodule
